// ===== design/cal_pkg.sv =====
// Shared types, constants and helpers for the comment-aware line counter.
// No dependencies; imported by cal_scan and comment_aware_line_counter.
package cal_pkg;

    localparam int MARKER_MAX_BYTES_DEF = 4;
    localparam int COUNT_WIDTH_DEF      = 32;

    localparam int MARKER_WIDTH = 32;
    localparam int LEN_WIDTH    = 3;
    localparam int CHAR_WIDTH   = 16;
    localparam int TOTAL_WIDTH  = 32;
    localparam int CFG_WIDTH    = 32;
    localparam int INDEX_WIDTH  = 3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_OPEN_MARKER      = 3'd0,
        REG_OPEN_MARKER_LEN  = 3'd1,
        REG_CLOSE_MARKER     = 3'd2,
        REG_CLOSE_MARKER_LEN = 3'd3,
        REG_LINE_MARKER      = 3'd4,
        REG_LINE_MARKER_LEN  = 3'd5,
        REG_MIN_CHARS        = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic in_block;
        logic in_line;
        logic count_char;
        logic end_line;
    } scan_flags_t;

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VTAB || b == CH_FF;
    endfunction

    // bytes beyond the 32-bit marker read as zero
    function automatic logic [7:0] marker_byte(input logic [MARKER_WIDTH-1:0] m,
                                               input logic [3:0] pos);
        logic [MARKER_WIDTH-1:0] sh;
        sh = m >> {pos[1:0], 3'b000};
        return (pos < 4'd4) ? sh[7:0] : 8'h00;
    endfunction

endpackage

// ===== design/cal_scan.sv =====
// Marker matcher and comment tracker for one text byte.
// Depends on cal_pkg for marker helpers and the flag struct.
module cal_scan
    import cal_pkg::*;
#(
    parameter int MARKER_MAX_BYTES = MARKER_MAX_BYTES_DEF,
    parameter int POS_WIDTH        = $clog2(MARKER_MAX_BYTES + 1)
)
(
    input  logic [7:0]              data_byte,
    input  logic                    in_block,
    input  logic                    in_line,
    input  logic [POS_WIDTH-1:0]    open_pos,
    input  logic [POS_WIDTH-1:0]    close_pos,
    input  logic [POS_WIDTH-1:0]    line_pos,
    input  logic [MARKER_WIDTH-1:0] open_marker,
    input  logic [LEN_WIDTH-1:0]    open_len,
    input  logic [MARKER_WIDTH-1:0] close_marker,
    input  logic [LEN_WIDTH-1:0]    close_len,
    input  logic [MARKER_WIDTH-1:0] line_marker,
    input  logic [LEN_WIDTH-1:0]    line_len,
    output logic [POS_WIDTH-1:0]    open_pos_next,
    output logic [POS_WIDTH-1:0]    close_pos_next,
    output logic [POS_WIDTH-1:0]    line_pos_next,
    output scan_flags_t             flags
);

    localparam int EXT_WIDTH = POS_WIDTH + 1;
    localparam logic [EXT_WIDTH-1:0] LEN_CAP = EXT_WIDTH'(MARKER_MAX_BYTES);

    logic [EXT_WIDTH-1:0] olen;
    logic [EXT_WIDTH-1:0] clen;
    logic [EXT_WIDTH-1:0] llen;
    logic [EXT_WIDTH-1:0] open_inc;
    logic [EXT_WIDTH-1:0] close_inc;
    logic [EXT_WIDTH-1:0] line_inc;
    logic                 open_hit;
    logic                 close_hit;
    logic                 line_hit;
    logic                 is_nl;

    function automatic logic [EXT_WIDTH-1:0] cap_len(input logic [LEN_WIDTH-1:0] len);
        logic [EXT_WIDTH+LEN_WIDTH-1:0] wide;
        wide = (EXT_WIDTH+LEN_WIDTH)'(len);
        return (wide > (EXT_WIDTH+LEN_WIDTH)'(MARKER_MAX_BYTES)) ? LEN_CAP
                                                                 : EXT_WIDTH'(wide);
    endfunction

    assign olen = cap_len(open_len);
    assign clen = cap_len(close_len);
    assign llen = cap_len(line_len);

    assign open_inc  = EXT_WIDTH'(open_pos) + 1'b1;
    assign close_inc = EXT_WIDTH'(close_pos) + 1'b1;
    assign line_inc  = EXT_WIDTH'(line_pos) + 1'b1;

    assign open_hit  = (olen != '0) && data_byte == marker_byte(open_marker, 4'(open_pos));
    assign line_hit  = (llen != '0) && data_byte == marker_byte(line_marker, 4'(line_pos));
    assign close_hit = (olen != '0) && (clen != '0)
                       && data_byte == marker_byte(close_marker, 4'(close_pos));
    assign is_nl     = data_byte == CH_NEWLINE;

    always_comb
    begin
        open_pos_next    = open_pos;
        close_pos_next   = close_pos;
        line_pos_next    = line_pos;
        flags.in_block   = in_block;
        flags.in_line    = in_line;
        flags.count_char = 1'b0;
        flags.end_line   = 1'b0;
        if (in_line && !is_nl)
        begin
            // drop comment text
        end
        else if (data_byte[7] || is_blank(data_byte))
        begin
            open_pos_next  = '0;
            close_pos_next = '0;
            line_pos_next  = '0;
        end
        else if (in_line)
        begin
            open_pos_next  = '0;
            close_pos_next = '0;
            line_pos_next  = '0;
            flags.in_line  = 1'b0;
            flags.end_line = 1'b1;
        end
        else if (!in_block && open_hit)
        begin
            if (open_inc >= olen)
            begin
                flags.in_block = 1'b1;
                open_pos_next  = '0;
            end
            else
            begin
                open_pos_next = POS_WIDTH'(open_inc);
            end
        end
        else if (!in_block && line_hit)
        begin
            if (line_inc >= llen)
            begin
                flags.in_line = 1'b1;
                line_pos_next = '0;
            end
            else
            begin
                line_pos_next = POS_WIDTH'(line_inc);
            end
        end
        else if (in_block && close_hit)
        begin
            if (close_inc >= clen)
            begin
                flags.in_block = 1'b0;
                close_pos_next = '0;
            end
            else
            begin
                close_pos_next = POS_WIDTH'(close_inc);
            end
        end
        else
        begin
            flags.count_char = !in_block;
            open_pos_next    = '0;
            close_pos_next   = '0;
            line_pos_next    = '0;
            flags.end_line   = is_nl;
        end
    end

endmodule

// ===== design/comment_aware_line_counter.sv =====
// Comment-aware line counter: input beat register, one-pass byte scan, totals register.
// Totals register onto m_tvalid as the end-of-stream beat leaves the input beat register.
// Throughput: one beat per cycle, set by the single registered scan stage, while no totals are unread.
// Reset clears valid flags, scan state, counts, markers, lengths and min_chars; stream
// state also clears after each end-of-stream beat. Depends on cal_pkg and cal_scan.
module comment_aware_line_counter
    import cal_pkg::*;
#(
    parameter int MARKER_MAX_BYTES = MARKER_MAX_BYTES_DEF,
    parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [7:0] data_byte
    input  logic                   s_tuser,  // [0] byte_present
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata   // [31:0] line_total, [63:32] code_line_total
);

    localparam int POS_WIDTH = $clog2(MARKER_MAX_BYTES + 1);

    logic [MARKER_WIDTH-1:0] open_marker_reg;
    logic [LEN_WIDTH-1:0]    open_len_reg;
    logic [MARKER_WIDTH-1:0] close_marker_reg;
    logic [LEN_WIDTH-1:0]    close_len_reg;
    logic [MARKER_WIDTH-1:0] line_marker_reg;
    logic [LEN_WIDTH-1:0]    line_len_reg;
    logic [CHAR_WIDTH-1:0]   min_chars_reg;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_present_reg;
    logic                    in_eos_reg;

    logic                    in_block_reg;
    logic                    in_line_reg;
    logic [POS_WIDTH-1:0]    open_pos_reg;
    logic [POS_WIDTH-1:0]    close_pos_reg;
    logic [POS_WIDTH-1:0]    line_pos_reg;
    logic [CHAR_WIDTH-1:0]   chars_reg;
    logic [COUNT_WIDTH-1:0]  lines_reg;
    logic [COUNT_WIDTH-1:0]  code_reg;
    logic                    last_nl_reg;
    logic                    any_reg;

    logic                    out_valid_reg;
    logic [63:0]             out_data_reg;

    logic [POS_WIDTH-1:0]    open_pos_next;
    logic [POS_WIDTH-1:0]    close_pos_next;
    logic [POS_WIDTH-1:0]    line_pos_next;
    scan_flags_t             flags;

    logic                    advance;
    logic                    take;
    logic [CHAR_WIDTH-1:0]   chars_next;
    logic                    any_next;
    logic                    last_nl_next;
    logic                    line_done;
    logic                    code_done;
    logic [COUNT_WIDTH-1:0]  lines_next;
    logic [COUNT_WIDTH-1:0]  code_next;
    logic [TOTAL_WIDTH-1:0]  line_total;
    logic [TOTAL_WIDTH-1:0]  code_total;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOTAL_WIDTH-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'(32'hFFFF_FFFF)) ? '1 : wide[TOTAL_WIDTH-1:0];
    endfunction

    cal_scan #(
        .MARKER_MAX_BYTES (MARKER_MAX_BYTES),
        .POS_WIDTH        (POS_WIDTH)
    ) u_scan (
        .data_byte      (in_byte_reg),
        .in_block       (in_block_reg),
        .in_line        (in_line_reg),
        .open_pos       (open_pos_reg),
        .close_pos      (close_pos_reg),
        .line_pos       (line_pos_reg),
        .open_marker    (open_marker_reg),
        .open_len       (open_len_reg),
        .close_marker   (close_marker_reg),
        .close_len      (close_len_reg),
        .line_marker    (line_marker_reg),
        .line_len       (line_len_reg),
        .open_pos_next  (open_pos_next),
        .close_pos_next (close_pos_next),
        .line_pos_next  (line_pos_next),
        .flags          (flags)
    );

    assign advance  = in_valid_reg && (!in_eos_reg || !out_valid_reg || m_tready);
    assign take     = advance && in_present_reg;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        chars_next = chars_reg;
        if (take && flags.count_char && chars_reg != '1)
        begin
            chars_next = chars_reg + 1'b1;
        end
        any_next     = any_reg || in_present_reg;
        last_nl_next = in_present_reg ? (in_byte_reg == CH_NEWLINE) : last_nl_reg;
        line_done    = (take && flags.end_line)
                       || (in_eos_reg && any_next && !last_nl_next);
        code_done    = line_done && (chars_next > min_chars_reg);
        lines_next   = line_done ? sat_inc(lines_reg) : lines_reg;
        code_next    = code_done ? sat_inc(code_reg) : code_reg;
        line_total   = clip(lines_next);
        code_total   = clip(code_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_marker_reg  <= '0;
            open_len_reg     <= '0;
            close_marker_reg <= '0;
            close_len_reg    <= '0;
            line_marker_reg  <= '0;
            line_len_reg     <= '0;
            min_chars_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_OPEN_MARKER:      open_marker_reg  <= cfg_data;
                REG_OPEN_MARKER_LEN:  open_len_reg     <= cfg_data[LEN_WIDTH-1:0];
                REG_CLOSE_MARKER:     close_marker_reg <= cfg_data;
                REG_CLOSE_MARKER_LEN: close_len_reg    <= cfg_data[LEN_WIDTH-1:0];
                REG_LINE_MARKER:      line_marker_reg  <= cfg_data;
                REG_LINE_MARKER_LEN:  line_len_reg     <= cfg_data[LEN_WIDTH-1:0];
                REG_MIN_CHARS:        min_chars_reg    <= cfg_data[CHAR_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_eos_reg     <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg  <= 1'b0;
            in_line_reg   <= 1'b0;
            open_pos_reg  <= '0;
            close_pos_reg <= '0;
            line_pos_reg  <= '0;
            chars_reg     <= '0;
            lines_reg     <= '0;
            code_reg      <= '0;
            last_nl_reg   <= 1'b0;
            any_reg       <= 1'b0;
        end
        else if (advance && in_eos_reg)
        begin
            in_block_reg  <= 1'b0;
            in_line_reg   <= 1'b0;
            open_pos_reg  <= '0;
            close_pos_reg <= '0;
            line_pos_reg  <= '0;
            chars_reg     <= '0;
            lines_reg     <= '0;
            code_reg      <= '0;
            last_nl_reg   <= 1'b0;
            any_reg       <= 1'b0;
        end
        else if (take)
        begin
            in_block_reg  <= flags.in_block;
            in_line_reg   <= flags.in_line;
            open_pos_reg  <= open_pos_next;
            close_pos_reg <= close_pos_next;
            line_pos_reg  <= line_pos_next;
            chars_reg     <= flags.end_line ? '0 : chars_next;
            lines_reg     <= lines_next;
            code_reg      <= code_next;
            last_nl_reg   <= last_nl_next;
            any_reg       <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_eos_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_eos_reg)
        begin
            out_data_reg <= {code_total, line_total};
        end
    end

endmodule
